@@ rtl/resident_id_checksum_validator_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the resident ID checksum validator
// Both macros sample on clk and are disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef RESIDENT_ID_CHECKSUM_VALIDATOR_MACROS_SVH
`define RESIDENT_ID_CHECKSUM_VALIDATOR_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold.
`define RICV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the following cycle.
`define RICV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/ricv_pkg.sv @@
// ----------------------------------------------------------------------------
// ricv_pkg
// Types, codes and helper functions shared by the validator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ricv_pkg;

  // Layout modes
  localparam logic [1:0] MODE_OFF         = 2'd0;
  localparam logic [1:0] MODE_DASH        = 2'd1;
  localparam logic [1:0] MODE_SPECIAL     = 2'd2;
  localparam logic [1:0] MODE_INTERLEAVED = 2'd3;

  localparam logic [7:0] CHAR_DASH  = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;

  localparam logic [4:0] MIN_LEN_SHORT = 5'd14;
  localparam logic [4:0] MIN_LEN_LONG  = 5'd27;
  localparam logic [4:0] POS_MAX       = 5'd31;

  typedef enum logic [1:0] {
    ROLE_NONE,
    ROLE_DIGIT,
    ROLE_SEP,
    ROLE_CHECK
  } ricv_role_t;

  typedef enum logic [2:0] {
    FAIL_NONE      = 3'd0,
    FAIL_SHORT     = 3'd1,
    FAIL_SEP       = 3'd2,
    FAIL_DIGIT     = 3'd3,
    FAIL_CHECKSUM  = 3'd4,
    FAIL_MODE_ZERO = 3'd5
  } ricv_fail_t;

  typedef struct packed {
    ricv_role_t role;
    logic [3:0] weight;
  } ricv_slot_t;

  // Classified character handed from front to back
  typedef struct packed {
    logic       last;
    logic       mode_zero;
    logic       too_short;
    ricv_role_t role;
    logic       is_digit;
    logic       sep_ok;
    logic [3:0] digit;
    logic [3:0] prod_mod;
  } ricv_item_t;

  // Codes 33 to 127 that are neither a digit nor a letter
  function automatic logic is_special(logic [7:0] c);
    logic ok;
    ok = 1'b1;
    if (c < 8'd33 || c > 8'd127) ok = 1'b0;
    if (c > 8'd47 && c < 8'd58) ok = 1'b0;
    if (c > 8'd64 && c < 8'd91) ok = 1'b0;
    if (c > 8'd96 && c < 8'd123) ok = 1'b0;
    return ok;
  endfunction

  // Weights of the second group of six digits
  function automatic logic [3:0] second_weight(logic [2:0] idx);
    logic [3:0] w;
    case (idx)
      3'd0:    w = 4'd8;
      3'd1:    w = 4'd9;
      3'd2:    w = 4'd2;
      3'd3:    w = 4'd3;
      3'd4:    w = 4'd4;
      3'd5:    w = 4'd5;
      default: w = 4'd0;
    endcase
    return w;
  endfunction

  function automatic ricv_slot_t slot_of(logic [1:0] m, logic [4:0] p);
    ricv_slot_t s;
    logic [4:0] off;
    s.role   = ROLE_NONE;
    s.weight = 4'd0;
    off      = 5'd0;
    if (m == MODE_DASH || m == MODE_SPECIAL) begin
      if (p < 5'd6) begin
        s.role   = ROLE_DIGIT;
        s.weight = p[3:0] + 4'd2;
      end else if (p == 5'd6) begin
        s.role = ROLE_SEP;
      end else if (p < 5'd13) begin
        off      = p - 5'd7;
        s.role   = ROLE_DIGIT;
        s.weight = second_weight(off[2:0]);
      end else if (p == 5'd13) begin
        s.role = ROLE_CHECK;
      end
    end else if (m == MODE_INTERLEAVED) begin
      if ((p <= 5'd25 && p[0]) || p == 5'd12) begin
        s.role = ROLE_SEP;
      end else if (p < 5'd12) begin
        s.role   = ROLE_DIGIT;
        s.weight = p[4:1] + 4'd2;
      end else if (p < 5'd26) begin
        off      = p - 5'd14;
        s.role   = ROLE_DIGIT;
        s.weight = second_weight(off[3:1]);
      end else if (p == 5'd26) begin
        s.role = ROLE_CHECK;
      end
    end
    return s;
  endfunction

  // v mod 11 for v below 128: reciprocal estimate, then one correction
  function automatic logic [3:0] mod11_small(logic [6:0] v);
    logic [14:0] t;
    logic [3:0]  q;
    logic [6:0]  r;
    t = 15'(v) * 15'd186;
    q = t[14:11];
    r = v - 7'(q) * 7'd11;
    if (r >= 7'd11) r = r - 7'd11;
    return r[3:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/resident_id_checksum_validator.sv @@
// ----------------------------------------------------------------------------
// resident_id_checksum_validator
// Check-digit validator for resident registration numbers, one byte a beat.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload                               Handshake
//  cfg       in   cfg_data: layout_mode[1:0]            cfg_valid/cfg_ready
//  s_axis    in   tdata: char_code[7:0]; tlast: end     s_axis_tvalid/tready
//  m_axis    out  tdata: is_match, fail_reason, check   m_axis_tvalid/tready
//
//  One input beat per cycle while the queue has room. The front classifies each
//  byte in the cycle it is accepted and pushes it into a FIFO_DEPTH-entry queue;
//  the back pops one entry per cycle unless a verdict waits at the output, and it
//  registers the verdict as it pops the tlast entry. Output stalls first fill the
//  output register, then the queue; s_axis_tready falls only when the queue is full.
//  Reset (rst, synchronous) sets layout_mode to 1 and clears all token state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module resident_id_checksum_validator #(
  parameter int FIFO_DEPTH = 4
) (
  input  wire        clk,
  input  wire        rst,
  // Configuration write: layout_mode
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire  [1:0] cfg_data,       // [1:0] layout_mode
  // Character stream
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire  [7:0] s_axis_tdata,   // [7:0] char_code
  input  wire        s_axis_tlast,   // token_end
  // Verdict stream
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] is_match, [3:1] fail_reason,
                                     // [7:4] expected_check
);
  import ricv_pkg::*;

  ricv_item_t push_item;
  ricv_item_t head;
  logic       push;
  logic       pop;
  logic       queue_full;
  logic       queue_empty;

  // Front: layout register, position counter, byte classification
  ricv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .char_code  (s_axis_tdata),
    .token_end  (s_axis_tlast),
    .queue_full (queue_full),
    .push       (push),
    .item       (push_item)
  );

  // Decouple the two halves so each side stalls on its own
  ricv_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .pop_item  (head),
    .empty     (queue_empty)
  );

  // Back: weighted sum mod 11, error flags, verdict register
  ricv_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_data    (m_axis_tdata)
  );

endmodule

`default_nettype wire

@@ rtl/ricv_queue.sv @@
// ----------------------------------------------------------------------------
// ricv_queue
// Small register FIFO of classified characters between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ricv_queue #(
  parameter int DEPTH = 4
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push,
  input  ricv_pkg::ricv_item_t  push_item,
  output logic                  full,
  input  wire                   pop,
  output ricv_pkg::ricv_item_t  pop_item,
  output logic                  empty
);
  import ricv_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ricv_item_t      slots [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/ricv_front.sv @@
// ----------------------------------------------------------------------------
// ricv_front
// Hold the layout mode, track the position in the token and classify bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ricv_front (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire  [1:0]            cfg_data,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  [7:0]            char_code,
  input  wire                   token_end,
  input  wire                   queue_full,
  output logic                  push,
  output ricv_pkg::ricv_item_t  item
);
  import ricv_pkg::*;

  logic [1:0] layout_mode;
  logic [4:0] position;
  logic [4:0] position_next;
  logic [4:0] len;
  logic [4:0] need;
  ricv_slot_t slot;
  logic       is_digit;
  logic [3:0] digit;
  logic [7:0] prod;
  logic [7:0] diff;

  assign cfg_ready = 1'b1;
  assign in_ready  = !queue_full;
  assign push      = in_valid && in_ready;

  always_comb begin
    slot     = slot_of(layout_mode, position);
    is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    diff     = char_code - CHAR_ZERO;
    digit    = is_digit ? diff[3:0] : 4'd0;
    prod     = 8'(digit) * 8'(slot.weight);
    len      = (position == POS_MAX) ? POS_MAX : position + 5'd1;
    need     = (layout_mode == MODE_INTERLEAVED) ? MIN_LEN_LONG : MIN_LEN_SHORT;

    item.last      = token_end;
    item.mode_zero = (layout_mode == MODE_OFF);
    item.too_short = (len < need);
    item.role      = slot.role;
    item.is_digit  = is_digit;
    item.sep_ok    = (layout_mode == MODE_DASH) ? (char_code == CHAR_DASH)
                                                : is_special(char_code);
    item.digit     = digit;
    item.prod_mod  = (slot.role == ROLE_DIGIT) ? mod11_small(prod[6:0]) : 4'd0;

    position_next  = token_end ? 5'd0 : len;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      layout_mode <= MODE_DASH;
      position    <= 5'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        layout_mode <= cfg_data;
      end
      if (push) begin
        position <= position_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/ricv_back.sv @@
// ----------------------------------------------------------------------------
// ricv_back
// Accumulate the token state from classified bytes and register the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ricv_back (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   queue_empty,
  input  ricv_pkg::ricv_item_t  head,
  output logic                  pop,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [7:0]            out_data
);
  import ricv_pkg::*;

  logic [3:0] sum_mod;
  logic       separator_bad;
  logic       digit_bad;
  logic [3:0] check_char;

  logic [3:0] sum_next;
  logic       separator_bad_next;
  logic       digit_bad_next;
  logic [3:0] check_char_next;
  logic [4:0] sum_add;
  logic [3:0] comp;
  logic [3:0] expect_chk;
  ricv_fail_t reason;

  always_comb begin
    pop = !queue_empty && (!head.last || !out_valid || out_ready);

    sum_next           = sum_mod;
    separator_bad_next = separator_bad;
    digit_bad_next     = digit_bad;
    check_char_next    = check_char;
    sum_add            = 5'(sum_mod) + 5'(head.prod_mod);

    case (head.role)
      ROLE_DIGIT: begin
        sum_next       = (sum_add >= 5'd11) ? 4'(sum_add - 5'd11) : sum_add[3:0];
        digit_bad_next = digit_bad || !head.is_digit;
      end
      ROLE_CHECK: begin
        check_char_next = head.digit;
        digit_bad_next  = digit_bad || !head.is_digit;
      end
      ROLE_SEP: begin
        separator_bad_next = separator_bad || !head.sep_ok;
      end
      default: begin
      end
    endcase

    comp       = 4'd11 - sum_next;
    expect_chk = (comp >= 4'd10) ? comp - 4'd10 : comp;

    if (head.mode_zero) begin
      reason = FAIL_MODE_ZERO;
    end else if (head.too_short) begin
      reason = FAIL_SHORT;
    end else if (separator_bad_next) begin
      reason = FAIL_SEP;
    end else if (digit_bad_next) begin
      reason = FAIL_DIGIT;
    end else if (expect_chk != check_char_next) begin
      reason = FAIL_CHECKSUM;
    end else begin
      reason = FAIL_NONE;
    end
  end

  // Token state: clear at the last byte, else take the update
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_mod       <= 4'd0;
      separator_bad <= 1'b0;
      digit_bad     <= 1'b0;
      check_char    <= 4'd0;
    end else if (pop) begin
      if (head.last) begin
        sum_mod       <= 4'd0;
        separator_bad <= 1'b0;
        digit_bad     <= 1'b0;
        check_char    <= 4'd0;
      end else begin
        sum_mod       <= sum_next;
        separator_bad <= separator_bad_next;
        digit_bad     <= digit_bad_next;
        check_char    <= check_char_next;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && head.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      out_data <= {expect_chk, reason, (reason == FAIL_NONE)};
    end
  end

endmodule

`default_nettype wire

@@ rtl/ricv_checker.sv @@
// ----------------------------------------------------------------------------
// ricv_checker
// Port-level checks on the verdict stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "resident_id_checksum_validator_macros.svh"

module ricv_checker (
  input wire       clk,
  input wire       rst,
  input wire       m_axis_tvalid,
  input wire       m_axis_tready,
  input wire [7:0] m_axis_tdata
);

  `RICV_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "verdict dropped or changed while stalled")
  `RICV_ASSERT_NOW(a_match_code, m_axis_tvalid, m_axis_tdata[0] == (m_axis_tdata[3:1] == 3'd0), "is_match disagrees with fail_reason")
  `RICV_ASSERT_NOW(a_reason_range, m_axis_tvalid, m_axis_tdata[3:1] <= 3'd5, "fail_reason out of range")
  `RICV_ASSERT_NOW(a_check_range, m_axis_tvalid, m_axis_tdata[7:4] <= 4'd9, "expected_check not a decimal digit")

endmodule

bind resident_id_checksum_validator ricv_checker u_ricv_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
